### hdl/multi_track_racetrack_store_unit_assert.svh
// Assertion macros for the racetrack store unit.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef MULTI_TRACK_RACETRACK_STORE_UNIT_ASSERT_SVH
`define MULTI_TRACK_RACETRACK_STORE_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define MTRS_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define MTRS_CHECK_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent that implies a consequent in the following cycle.
`define MTRS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mtrs_pkg.sv
// Shared types and constants of the racetrack store unit.
// Depends on nothing; used by mtrs_row and multi_track_racetrack_store_unit.
`timescale 1ns / 1ps

package mtrs_pkg;

	localparam int MaxResults = 32;

	typedef enum logic [2:0] {
		CMD_INS_LEFT    = 3'd0,
		CMD_INS_RIGHT   = 3'd1,
		CMD_DEL_LEFT    = 3'd2,
		CMD_DEL_RIGHT   = 3'd3,
		CMD_UPDATE      = 3'd4,
		CMD_READ_ALL    = 3'd5,
		CMD_SHIFT_LEFT  = 3'd6,
		CMD_SHIFT_RIGHT = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_OP,
		S_POST,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic shr;
		logic shl;
		logic op_en;
		cmd_t cmd;
	} row_ctrl_t;

	function automatic int head_pos(input int h, input int interval, input int cap);
		int p;
		p = interval - 1 + h * interval;
		if (p > cap - 1) begin
			p = cap - 1;
		end
		return p;
	endfunction

endpackage

### hdl/mtrs_row.sv
// Word row of the racetrack store: one-place shifts and the edit at a head.
// Depends on mtrs_pkg for the control struct, command codes and head positions.
`timescale 1ns / 1ps

module mtrs_row #(
	parameter int CAP      = 39,
	parameter int INTERVAL = 8,
	parameter int HEADS    = 4,
	parameter int TRACKS   = 4,
	parameter int IW       = 6,
	parameter int JW       = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mtrs_pkg::row_ctrl_t   ctrl,
	input  logic [IW-1:0]         pos,
	input  logic [TRACKS-1:0]     value,
	input  logic [JW-1:0]         head_sel,
	output logic [TRACKS-1:0]     head_word
);

	logic [TRACKS-1:0] row_q [CAP];
	logic [TRACKS-1:0] row_d [CAP];
	logic [TRACKS-1:0] taps [HEADS];

	for (genvar h = 0; h < HEADS; h++) begin : g_tap
		localparam int HP = mtrs_pkg::head_pos(h, INTERVAL, CAP);
		assign taps[h] = row_q[HP];
	end

	assign head_word = taps[head_sel];

	always_comb begin
		for (int k = 0; k < CAP; k++) begin
			row_d[k] = row_q[k];
		end
		if (ctrl.shr) begin
			row_d[0] = '0;
			for (int k = 1; k < CAP; k++) begin
				row_d[k] = row_q[k-1];
			end
		end else if (ctrl.shl) begin
			row_d[CAP-1] = '0;
			for (int k = 0; k < CAP - 1; k++) begin
				row_d[k] = row_q[k+1];
			end
		end else if (ctrl.op_en) begin
			case (ctrl.cmd)
				mtrs_pkg::CMD_INS_LEFT: begin
					for (int k = 0; k < CAP - 1; k++) begin
						if (IW'(k) < pos) begin
							row_d[k] = row_q[k+1];
						end
					end
					for (int k = 0; k < CAP; k++) begin
						if (IW'(k) == pos) begin
							row_d[k] = value;
						end
					end
				end
				mtrs_pkg::CMD_INS_RIGHT: begin
					for (int k = 1; k < CAP; k++) begin
						if (IW'(k) > pos) begin
							row_d[k] = row_q[k-1];
						end
					end
					for (int k = 0; k < CAP; k++) begin
						if (IW'(k) == pos) begin
							row_d[k] = value;
						end
					end
				end
				mtrs_pkg::CMD_DEL_LEFT: begin
					for (int k = 1; k < CAP; k++) begin
						if (IW'(k) <= pos) begin
							row_d[k] = row_q[k-1];
						end
					end
					row_d[0] = '0;
				end
				mtrs_pkg::CMD_DEL_RIGHT: begin
					for (int k = 0; k < CAP - 1; k++) begin
						if (IW'(k) >= pos) begin
							row_d[k] = row_q[k+1];
						end
					end
					row_d[CAP-1] = '0;
				end
				default: begin
					for (int k = 0; k < CAP; k++) begin
						if (IW'(k) == pos) begin
							row_d[k] = value;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CAP; k++) begin
				row_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < CAP; k++) begin
				row_q[k] <= row_d[k];
			end
		end
	end

endmodule

### hdl/multi_track_racetrack_store_unit.sv
// Top level of the racetrack store unit: command sequencer and result register.
// Depends on mtrs_pkg, mtrs_row and the assertion macro header.
//
//   Channel  Handshake                   Fields
//   item     item_valid / item_ready     command, index, value, step
//   result   result_valid / result_ready word, last
//
// The row moves one place per cycle unless a dump waits on result_ready, so every command is paced by that shift.
// An access shifts the index to its head and back, by the distance d between index and head, capped at the row length.
// A shift command moves the row by step places, capped at the row length.
// A dump emits a word whenever the result register is free, then shifts the row back into place.
// Reset clears the row and the sequencer at once; item_ready is high only when idle.
`timescale 1ns / 1ps
`include "multi_track_racetrack_store_unit_assert.svh"

module multi_track_racetrack_store_unit #(
	parameter int VOLUME = 32,
	parameter int HEADS  = 4,
	parameter int TRACKS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [2:0] command,
	input  logic [4:0] index,
	input  logic [3:0] value,
	input  logic [5:0] step,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [3:0] word,
	output logic       last
);

	localparam int INTERVAL = (VOLUME / HEADS > 0) ? VOLUME / HEADS : 1;
	localparam int CAP      = VOLUME + INTERVAL - 1;
	localparam int IW       = $clog2(CAP);
	localparam int CW       = $clog2(CAP + 1);
	localparam int DW       = (CW > 6) ? CW : 6;
	localparam int JW       = (HEADS > 1) ? $clog2(HEADS) : 1;
	localparam int XW       = (INTERVAL > 1) ? $clog2(INTERVAL) : 1;
	localparam int TOTAL    = (INTERVAL * HEADS > mtrs_pkg::MaxResults) ?
		mtrs_pkg::MaxResults : INTERVAL * HEADS;
	localparam int NW       = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int HCW      = $clog2(HEADS + 1);

	mtrs_pkg::state_t    state_q, state_d;
	mtrs_pkg::cmd_t      cmd_q, cmd_d, cmd_in;
	mtrs_pkg::row_ctrl_t ctrl;

	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     dist_q, dist_d;
	logic              dir_q, dir_d;
	logic              rd_q, rd_d;
	logic [IW-1:0]     pos_q, pos_d;
	logic [TRACKS-1:0] value_q, value_d;
	logic [XW-1:0]     i_q, i_d;
	logic [JW-1:0]     j_q, j_d;
	logic [NW-1:0]     n_q, n_d;
	logic              ov_q, ov_d;
	logic [3:0]        word_q, word_d;
	logic              last_q, last_d;

	logic [HCW-1:0]    head_acc;
	logic [IW-1:0]     pos_acc;
	logic [DW-1:0]     diff_acc;
	logic [CW-1:0]     dist_acc;
	logic              right_acc;
	logic [CW-1:0]     step_sat;
	logic [TRACKS-1:0] head_word;
	logic              slot_free;
	logic              wrap;
	logic              shift_now;
	logic              final_word;

	assign cmd_in     = mtrs_pkg::cmd_t'(command);
	assign slot_free  = !ov_q || result_ready;
	assign wrap       = (j_q == JW'(HEADS - 1));
	assign shift_now  = wrap && (i_q != XW'(INTERVAL - 1));
	assign final_word = (n_q == NW'(TOTAL - 1));

	// Head number is the count of head boundaries at or below the index.
	always_comb begin
		head_acc = '0;
		for (int h = 1; h < HEADS; h++) begin
			if (DW'(index) >= DW'(h * INTERVAL)) begin
				head_acc = head_acc + HCW'(1);
			end
		end
	end

	always_comb begin
		pos_acc = '0;
		for (int h = 0; h < HEADS; h++) begin
			if (head_acc == HCW'(h)) begin
				pos_acc = IW'(mtrs_pkg::head_pos(h, INTERVAL, CAP));
			end
		end
	end

	always_comb begin
		right_acc = DW'(pos_acc) > DW'(index);
		diff_acc  = right_acc ? DW'(pos_acc) - DW'(index) : DW'(index) - DW'(pos_acc);
		dist_acc  = (diff_acc >= DW'(CAP)) ? CW'(CAP) : CW'(diff_acc);
		step_sat  = (DW'(step) >= DW'(CAP)) ? CW'(CAP) : CW'(step);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtrs_pkg::S_IDLE: begin
				if (item_valid) begin
					if (cmd_in == mtrs_pkg::CMD_READ_ALL) begin
						state_d = mtrs_pkg::S_EMIT;
					end else if (cmd_in == mtrs_pkg::CMD_SHIFT_LEFT ||
						cmd_in == mtrs_pkg::CMD_SHIFT_RIGHT) begin
						state_d = mtrs_pkg::S_POST;
					end else begin
						state_d = mtrs_pkg::S_PRE;
					end
				end
			end
			mtrs_pkg::S_PRE: begin
				if (cnt_q == '0) begin
					state_d = rd_q ? mtrs_pkg::S_POST : mtrs_pkg::S_OP;
				end
			end
			mtrs_pkg::S_OP: begin
				state_d = mtrs_pkg::S_POST;
			end
			mtrs_pkg::S_POST: begin
				if (cnt_q == '0) begin
					state_d = mtrs_pkg::S_IDLE;
				end
			end
			mtrs_pkg::S_EMIT: begin
				if (slot_free && final_word) begin
					state_d = mtrs_pkg::S_PRE;
				end
			end
			default: begin
				state_d = mtrs_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_d   = cmd_q;
		cnt_d   = cnt_q;
		dist_d  = dist_q;
		dir_d   = dir_q;
		rd_d    = rd_q;
		pos_d   = pos_q;
		value_d = value_q;
		i_d     = i_q;
		j_d     = j_q;
		n_d     = n_q;
		ov_d    = ov_q && !result_ready;
		word_d  = word_q;
		last_d  = last_q;
		ctrl.shr   = 1'b0;
		ctrl.shl   = 1'b0;
		ctrl.op_en = 1'b0;
		ctrl.cmd   = cmd_q;
		item_ready = (state_q == mtrs_pkg::S_IDLE);
		case (state_q)
			mtrs_pkg::S_IDLE: begin
				if (item_valid) begin
					case (cmd_in)
						mtrs_pkg::CMD_READ_ALL: begin
							i_d  = '0;
							j_d  = '0;
							n_d  = '0;
							rd_d = 1'b1;
						end
						mtrs_pkg::CMD_SHIFT_LEFT: begin
							cnt_d = step_sat;
							dir_d = 1'b0;
							rd_d  = 1'b0;
						end
						mtrs_pkg::CMD_SHIFT_RIGHT: begin
							cnt_d = step_sat;
							dir_d = 1'b1;
							rd_d  = 1'b0;
						end
						default: begin
							cmd_d   = cmd_in;
							pos_d   = pos_acc;
							value_d = value[TRACKS-1:0];
							cnt_d   = dist_acc;
							dist_d  = dist_acc;
							dir_d   = right_acc;
							rd_d    = 1'b0;
						end
					endcase
				end
			end
			mtrs_pkg::S_PRE: begin
				if (cnt_q != '0) begin
					ctrl.shr = dir_q;
					ctrl.shl = !dir_q;
					cnt_d    = cnt_q - CW'(1);
				end else if (rd_q) begin
					cnt_d = CW'(INTERVAL - 1);
					dir_d = 1'b0;
				end
			end
			mtrs_pkg::S_OP: begin
				ctrl.op_en = 1'b1;
				cnt_d      = dist_q;
				dir_d      = !dir_q;
			end
			mtrs_pkg::S_POST: begin
				if (cnt_q != '0) begin
					ctrl.shr = dir_q;
					ctrl.shl = !dir_q;
					cnt_d    = cnt_q - CW'(1);
				end
			end
			mtrs_pkg::S_EMIT: begin
				if (slot_free) begin
					ov_d   = 1'b1;
					word_d = 4'(head_word);
					last_d = final_word;
					n_d    = n_q + NW'(1);
					if (wrap) begin
						j_d = '0;
						if (shift_now) begin
							ctrl.shr = 1'b1;
							i_d      = i_q + XW'(1);
						end
					end else begin
						j_d = j_q + JW'(1);
					end
					if (final_word) begin
						cnt_d = CW'(INTERVAL - 1) - CW'(i_q) - CW'(shift_now);
						dir_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtrs_pkg::S_IDLE;
			cnt_q   <= '0;
			dir_q   <= 1'b0;
			rd_q    <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dir_q   <= dir_d;
			rd_q    <= rd_d;
			i_q     <= i_d;
			j_q     <= j_d;
			n_q     <= n_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		dist_q  <= dist_d;
		pos_q   <= pos_d;
		value_q <= value_d;
		word_q  <= word_d;
		last_q  <= last_d;
	end

	mtrs_row #(
		.CAP      (CAP),
		.INTERVAL (INTERVAL),
		.HEADS    (HEADS),
		.TRACKS   (TRACKS),
		.IW       (IW),
		.JW       (JW)
	) u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.pos       (pos_q),
		.value     (value_q),
		.head_sel  (j_q),
		.head_word (head_word)
	);

	assign result_valid = ov_q;
	assign word         = word_q;
	assign last         = last_q;

	`MTRS_CHECK_IMP(a_result_from_dump, $rose(ov_q), $past(state_q == mtrs_pkg::S_EMIT), "A result appeared outside a dump.")
	`MTRS_CHECK_IMP(a_count_in_range, (state_q == mtrs_pkg::S_PRE || state_q == mtrs_pkg::S_POST), (cnt_q <= CW'(CAP)), "Shift count exceeds the row length.")
	`MTRS_CHECK_NEXT(a_busy_after_accept, (item_valid && item_ready), (state_q != mtrs_pkg::S_IDLE), "Sequencer stayed idle after a transaction.")
	`MTRS_CHECK_IMP(a_dump_offset, (state_q == mtrs_pkg::S_EMIT), (i_q <= XW'(INTERVAL - 1)), "Dump offset ran past the head interval.")

endmodule
